/* rtl/quaternion_to_euler_angles_core_macros.svh */
// Assertion macros for the quaternion to Euler angle pipeline.
`ifndef QUATERNION_TO_EULER_ANGLES_CORE_MACROS_SVH
`define QUATERNION_TO_EULER_ANGLES_CORE_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define Q2E_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition implies another on the next clock edge.
`define Q2E_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

/* rtl/q2e_pkg.sv */
package q2e_pkg;

	localparam int CordicStages = 16;
	// Guard width for the vectoring datapath: values stay well inside 40 bits.
	localparam int VecW = 40;
	localparam int AngW = 33;
	localparam int SqW = 57;
	localparam int SqLevels = 29;

	typedef logic signed [VecW-1:0] vec_t;
	typedef logic signed [AngW-1:0] ang_t;

	localparam logic signed [VecW-1:0] OneQ28 = 40'sd268435456;

	function automatic ang_t atan_entry(input int i);
		ang_t r;
		case (i)
			0: r = 33'sh020000000;
			1: r = 33'sh012E4051E;
			2: r = 33'sh009FB385B;
			3: r = 33'sh0051111D4;
			4: r = 33'sh0028B0D43;
			5: r = 33'sh00145D7E1;
			6: r = 33'sh000A2F61E;
			7: r = 33'sh000517C55;
			8: r = 33'sh00028BE53;
			9: r = 33'sh000145F2F;
			10: r = 33'sh0000A2F98;
			11: r = 33'sh0000517CC;
			12: r = 33'sh000028BE6;
			13: r = 33'sh0000145F3;
			14: r = 33'sh00000A2FA;
			15: r = 33'sh00000517D;
			16: r = 33'sh0000028BE;
			17: r = 33'sh00000145F;
			18: r = 33'sh000000A30;
			19: r = 33'sh000000518;
			20: r = 33'sh00000028C;
			21: r = 33'sh000000146;
			22: r = 33'sh0000000A3;
			23: r = 33'sh000000051;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [15:0] round_angle(input ang_t z);
		ang_t t;
		t = z + 33'sd32768;
		return t[31:16];
	endfunction

endpackage

/* rtl/q2e_cordic.sv */
// Pipelined vectoring CORDIC: one micro-rotation per register stage.
module q2e_cordic (
	input  logic                 clk,
	input  logic                 adv,
	input  q2e_pkg::vec_t        y_in,
	input  q2e_pkg::vec_t        x_in,
	output logic signed [15:0]   angle
);
	localparam int N = q2e_pkg::CordicStages;

	q2e_pkg::vec_t xs [N+1];
	q2e_pkg::vec_t ys [N+1];
	q2e_pkg::ang_t zs [N+1];
	logic          zero_s [N+1];

	// Pre-rotation into the right half plane.
	always_ff @(posedge clk) begin
		if (adv) begin
			zero_s[0] <= (x_in == '0) && (y_in == '0);
			if (x_in < 0) begin
				if (y_in >= 0) begin
					xs[0] <= y_in;
					ys[0] <= -x_in;
					zs[0] <= 33'sh040000000;
				end else begin
					xs[0] <= -y_in;
					ys[0] <= x_in;
					zs[0] <= -33'sh040000000;
				end
			end else begin
				xs[0] <= x_in;
				ys[0] <= y_in;
				zs[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_stage
		always_ff @(posedge clk) begin
			if (adv) begin
				zero_s[i+1] <= zero_s[i];
				if (ys[i] >= 0) begin
					xs[i+1] <= xs[i] + (ys[i] >>> i);
					ys[i+1] <= ys[i] - (xs[i] >>> i);
					zs[i+1] <= zs[i] + q2e_pkg::atan_entry(i);
				end else begin
					xs[i+1] <= xs[i] - (ys[i] >>> i);
					ys[i+1] <= ys[i] + (xs[i] >>> i);
					zs[i+1] <= zs[i] - q2e_pkg::atan_entry(i);
				end
			end
		end
	end

	assign angle = zero_s[N] ? 16'sd0 : q2e_pkg::round_angle(zs[N]);
endmodule

/* rtl/q2e_isqrt.sv */
// Pipelined integer square root, one result bit resolved per stage.
module q2e_isqrt (
	input  logic                      clk,
	input  logic                      adv,
	input  logic [q2e_pkg::SqW-1:0]   rad,
	output logic [q2e_pkg::SqW-1:0]   root
);
	localparam int L = q2e_pkg::SqLevels;
	localparam int W = q2e_pkg::SqW;

	logic [W-1:0] v_s [L+1];
	logic [W-1:0] r_s [L+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			v_s[0] <= rad;
			r_s[0] <= '0;
		end
	end

	for (genvar k = 0; k < L; k++) begin : g_lvl
		localparam logic [W-1:0] Bit = W'(1) << (2 * (L - 1 - k));
		always_ff @(posedge clk) begin
			if (adv) begin
				if (v_s[k] >= r_s[k] + Bit) begin
					v_s[k+1] <= v_s[k] - (r_s[k] + Bit);
					r_s[k+1] <= (r_s[k] >> 1) + Bit;
				end else begin
					v_s[k+1] <= v_s[k];
					r_s[k+1] <= r_s[k] >> 1;
				end
			end
		end
	end

	assign root = r_s[L];
endmodule

/* rtl/quaternion_to_euler_angles_core.sv */
// The pipeline holds 4 front stages, 30 square root stages, 17 CORDIC stages and the
// output register: 52 register stages in all.
// Throughput: one word per cycle; the whole pipeline advances unless the output
// is stalled while holding a word.
// Reset clears only the valid bits; the data path registers are not reset.
module quaternion_to_euler_angles_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] quat_w,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] roll_angle,
	output logic signed [15:0] pitch_angle,
	output logic signed [15:0] yaw_angle,
	output logic               pitch_saturated
);
	`include "quaternion_to_euler_angles_core_macros.svh"

	localparam int Depth = 4 + (q2e_pkg::SqLevels + 1) + (q2e_pkg::CordicStages + 1) + 1;

	logic             adv;
	logic [Depth-1:0] vld_q;

	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;
	assign out_valid = vld_q[Depth-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[Depth-2:0], in_valid};
		end
	end

	// Stage 1: products.
	logic signed [31:0] wx_s1, yz_s1, xx_s1, yy_s1, zz_s1, wz_s1, xy_s1, wy_s1, xz_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			wx_s1 <= quat_w * quat_x;
			yz_s1 <= quat_y * quat_z;
			xx_s1 <= quat_x * quat_x;
			yy_s1 <= quat_y * quat_y;
			zz_s1 <= quat_z * quat_z;
			wz_s1 <= quat_w * quat_z;
			xy_s1 <= quat_x * quat_y;
			wy_s1 <= quat_w * quat_y;
			xz_s1 <= quat_x * quat_z;
		end
	end

	// Stage 2: numerators, denominators and the pitch sine.
	q2e_pkg::vec_t rn_s2, rd_s2, yn_s2, yd_s2, s_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			rn_s2 <= 2 * (40'(wx_s1) + 40'(yz_s1));
			rd_s2 <= q2e_pkg::OneQ28 - 2 * (40'(xx_s1) + 40'(yy_s1));
			yn_s2 <= 2 * (40'(wz_s1) + 40'(xy_s1));
			yd_s2 <= q2e_pkg::OneQ28 - 2 * (40'(yy_s1) + 40'(zz_s1));
			s_s2 <= 2 * (40'(wy_s1) - 40'(xz_s1));
		end
	end

	// Stage 3: range check and |s| (fits 28 bits inside the unit range).
	logic         big_s3, sat_s3, pos_s3;
	logic [27:0]  sa_s3;
	q2e_pkg::vec_t s_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			big_s3 <= (s_s2 >= q2e_pkg::OneQ28) || (s_s2 <= -q2e_pkg::OneQ28);
			sat_s3 <= (s_s2 > q2e_pkg::OneQ28) || (s_s2 < -q2e_pkg::OneQ28);
			pos_s3 <= s_s2 > 0;
			sa_s3 <= 28'(s_s2 < 0 ? -s_s2 : s_s2);
			s_s3 <= s_s2;
		end
	end

	// Stage 4: radicand 2^56 - s^2 (28 by 28 multiplier).
	logic [q2e_pkg::SqW-1:0] rad_s4;
	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s4 <= (57'(1) << 56) - 57'(56'(sa_s3) * 56'(sa_s3));
		end
	end

	// Delay lines to align everything with the square root output.
	localparam int DS = q2e_pkg::SqLevels;
	q2e_pkg::vec_t rn_d [DS+3], rd_d [DS+3], yn_d [DS+3], yd_d [DS+3], s_d [DS+2];
	logic          big_d [DS+2], sat_d [DS+2], pos_d [DS+2];

	always_ff @(posedge clk) begin
		if (adv) begin
			rn_d[0] <= rn_s2; rd_d[0] <= rd_s2; yn_d[0] <= yn_s2; yd_d[0] <= yd_s2;
			s_d[0] <= s_s3; big_d[0] <= big_s3; sat_d[0] <= sat_s3; pos_d[0] <= pos_s3;
			for (int k = 0; k < DS + 2; k++) begin
				rn_d[k+1] <= rn_d[k]; rd_d[k+1] <= rd_d[k];
				yn_d[k+1] <= yn_d[k]; yd_d[k+1] <= yd_d[k];
			end
			for (int k = 0; k < DS + 1; k++) begin
				s_d[k+1] <= s_d[k]; big_d[k+1] <= big_d[k];
				sat_d[k+1] <= sat_d[k]; pos_d[k+1] <= pos_d[k];
			end
		end
	end

	logic [q2e_pkg::SqW-1:0] root;
	q2e_isqrt u_sqrt (.clk(clk), .adv(adv), .rad(rad_s4), .root(root));

	// Operands enter the CORDICs aligned: roll/yaw fed from delay taps.
	logic signed [15:0] roll_a, yaw_a, pitch_a;
	q2e_cordic u_roll (.clk(clk), .adv(adv),
		.y_in(rn_d[DS+2]), .x_in(rd_d[DS+2]), .angle(roll_a));
	q2e_cordic u_yaw (.clk(clk), .adv(adv),
		.y_in(yn_d[DS+2]), .x_in(yd_d[DS+2]), .angle(yaw_a));
	q2e_cordic u_pitch (.clk(clk), .adv(adv),
		.y_in(s_d[DS+1]), .x_in(40'(root)), .angle(pitch_a));

	// Side band of the pitch path through the CORDIC depth.
	localparam int DC = q2e_pkg::CordicStages + 1;
	logic big_c [DC], sat_c [DC], pos_c [DC];
	always_ff @(posedge clk) begin
		if (adv) begin
			big_c[0] <= big_d[DS+1]; sat_c[0] <= sat_d[DS+1]; pos_c[0] <= pos_d[DS+1];
			for (int k = 0; k < DC - 1; k++) begin
				big_c[k+1] <= big_c[k]; sat_c[k+1] <= sat_c[k]; pos_c[k+1] <= pos_c[k];
			end
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (adv) begin
			roll_angle <= roll_a;
			yaw_angle <= yaw_a;
			pitch_saturated <= sat_c[DC-1];
			if (big_c[DC-1]) begin
				pitch_angle <= pos_c[DC-1] ? 16'sd16384 : -16'sd16384;
			end else if (pitch_a > 16'sd16384) begin
				pitch_angle <= 16'sd16384;
			end else if (pitch_a < -16'sd16384) begin
				pitch_angle <= -16'sd16384;
			end else begin
				pitch_angle <= pitch_a;
			end
		end
	end

	`Q2E_ASSERT(a_pitch_range, clk, arst_n,
		!out_valid || (pitch_angle <= 16'sd16384 && pitch_angle >= -16'sd16384),
		"pitch out of range")
	`Q2E_ASSERT(a_sat_implies_edge, clk, arst_n,
		!(out_valid && pitch_saturated) ||
		pitch_angle == 16'sd16384 || pitch_angle == -16'sd16384,
		"saturation flag without clamped pitch")
	`Q2E_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(roll_angle) && $stable(pitch_angle), "stalled word changed")
endmodule

/* verif/euler_checker.sv */
module euler_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [15:0] quat_w,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [15:0] roll_angle,
	input  logic signed [15:0] pitch_angle,
	input  logic signed [15:0] yaw_angle,
	input  logic               pitch_saturated,
	output int                 fail_count,
	output int                 pending_count,
	output int                 sat_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [15:0] roll;
		logic signed [15:0] pitch;
		logic signed [15:0] yaw;
		logic               sat;
	} euler_t;

	localparam longint OneQ28 = 64'sd1 << 28;

	euler_t pending_angles[$];

	function automatic longint floor_shift(input longint v, input int s);
		return v >>> s;
	endfunction

	// Vectoring CORDIC, angle in 32-bit binary units where 2^31 is pi.
	function automatic longint vector_angle(input longint yy, input longint xx);
		longint acc;
		longint t;
		longint dx;
		longint dy;
		acc = 0;
		if (xx == 0 && yy == 0)
			return 0;
		if (xx < 0) begin
			if (yy >= 0) begin
				t = xx; xx = yy; yy = -t; acc = 64'sd1 << 30;
			end else begin
				t = xx; xx = -yy; yy = t; acc = -(64'sd1 << 30);
			end
		end
		for (int i = 0; i < q2e_pkg::CordicStages; i++) begin
			dx = floor_shift(yy, i);
			dy = floor_shift(xx, i);
			if (yy >= 0) begin
				xx += dx; yy -= dy; acc += longint'(q2e_pkg::atan_entry(i));
			end else begin
				xx -= dx; yy += dy; acc -= longint'(q2e_pkg::atan_entry(i));
			end
		end
		return acc;
	endfunction

	function automatic logic signed [15:0] to_bam16(input longint z);
		longint u;
		u = z + 32768;
		return u[31:16];
	endfunction

	function automatic longint int_sqrt(input longint v);
		longint r;
		longint b;
		r = 0;
		b = 64'sd1 << 60;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic euler_t predict_euler(input longint w, input longint x,
			input longint y, input longint z);
		euler_t e;
		longint s;
		longint p;
		e.sat = 1'b0;
		e.roll = to_bam16(vector_angle(2 * (w * x + y * z), OneQ28 - 2 * (x * x + y * y)));
		e.yaw = to_bam16(vector_angle(2 * (w * z + x * y), OneQ28 - 2 * (y * y + z * z)));
		s = 2 * (w * y - x * z);
		if (s >= OneQ28 || s <= -OneQ28) begin
			e.sat = (s > OneQ28 || s < -OneQ28);
			e.pitch = (s > 0) ? 16'sd16384 : -16'sd16384;
		end else begin
			p = to_bam16(vector_angle(s, int_sqrt(OneQ28 * OneQ28 - s * s)));
			if (p > 16384) p = 16384;
			if (p < -16384) p = -16384;
			e.pitch = 16'(p);
		end
		return e;
	endfunction

	initial begin
		fail_count = 0;
		sat_seen = 0;
	end

	assign pending_count = pending_angles.size();

	always @(posedge clk) begin
		euler_t exp_e;
		if (arst_n && in_valid && !in_stall)
			pending_angles.insert(pending_angles.size(),
				predict_euler(quat_w, quat_x, quat_y, quat_z));
		if (arst_n && out_valid && !out_stall) begin
			if (pending_angles.size() == 0) begin
				$display("%0t: unexpected word roll=%0d pitch=%0d yaw=%0d sat=%0b", $time,
					roll_angle, pitch_angle, yaw_angle, pitch_saturated);
				fail_count++;
			end else begin
				exp_e = pending_angles.pop_front();
				if (pitch_saturated) sat_seen++;
				if ({roll_angle, pitch_angle, yaw_angle, pitch_saturated} !== exp_e) begin
					$display("%0t: mismatch expected roll=%0d pitch=%0d yaw=%0d sat=%0b",
						$time, exp_e.roll, exp_e.pitch, exp_e.yaw, exp_e.sat);
					$display("%0t:          actual   roll=%0d pitch=%0d yaw=%0d sat=%0b",
						$time, roll_angle, pitch_angle, yaw_angle, pitch_saturated);
					fail_count++;
				end
			end
		end
	end
endmodule

/* verif/testbench.sv */
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [15:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] roll_angle, pitch_angle, yaw_angle;
	logic pitch_saturated;
	int fail_count, pending_count, sat_seen;
	int send_idle_pct = 20;
	int recv_idle_pct = 74;
	int sent_words = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	quaternion_to_euler_angles_core dut (.*);
	euler_checker checker_i (.*);

	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_idle_pct);

	// Holds the word until the block takes it; idles at random between words.
	task automatic send_quat(input logic [15:0] w, x, y, z);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		quat_w <= w; quat_x <= x; quat_y <= y; quat_z <= z;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent_words++;
	endtask

	task automatic send_random(input int n);
		int r;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(9);
			if (r < 6) begin
				// Near-unit quaternions: small noise around a normalized direction.
				real a, b, c, d, m;
				a = $urandom_range(65535) - 32768.0;
				b = $urandom_range(65535) - 32768.0;
				c = $urandom_range(65535) - 32768.0;
				d = $urandom_range(65535) - 32768.0;
				m = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
				send_quat(16'($rtoi(16384.0 * a / m) + $urandom_range(6) - 3),
					16'($rtoi(16384.0 * b / m) + $urandom_range(6) - 3),
					16'($rtoi(16384.0 * c / m) + $urandom_range(6) - 3),
					16'($rtoi(16384.0 * d / m) + $urandom_range(6) - 3));
			end else if (r < 8) begin
				send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
			end else begin
				send_quat(16'($urandom_range(16384) - 8192),
					16'($urandom_range(511) - 256),
					16'($urandom_range(16384) - 8192),
					16'($urandom_range(511) - 256));
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Identity, zero vector, extremes, pi rotations and gimbal lock.
		send_quat(16384, 0, 0, 0);
		send_quat(0, 0, 0, 0);
		send_quat(-32768, -32768, -32768, -32768);
		send_quat(32767, 32767, 32767, 32767);
		send_quat(-32768, 32767, -32768, 32767);
		send_quat(0, 16384, 0, 0);
		send_quat(0, 0, 16384, 0);
		send_quat(0, 0, 0, 16384);
		send_quat(0, -16384, 0, 0);
		send_quat(11585, 0, 11585, 0);
		send_quat(11585, 0, -11585, 0);
		send_quat(11586, 0, 11586, 0);
		send_quat(11586, 0, -11586, 0);
		send_quat(8192, 8192, 8192, -8192);
		send_quat(8192, -8192, 8192, 8192);
		send_quat(11585, 11585, 0, 0);
		send_quat(11585, 0, 0, -11585);
		send_quat(1, -1, 1, -1);
		send_quat(0, 0, 23170, 0);
		send_quat(16384, 0, 8192, 0);
		send_random(380);
		send_idle_pct = 74;
		recv_idle_pct = 20;
		in_valid <= 1'b0;
		while (pending_count != 0) @(posedge clk);
		send_random(380);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_random(380);
		in_valid <= 1'b0;
		while (pending_count != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		$display("Sent %0d words: directed corners, near-unit, raw and gimbal-lock poses,",
			sent_words);
		$display("under three idling mixes; %0d results had pitch clamped.", sat_seen);
		if (fail_count == 0)
			$display("** quaternion_to_euler_angles_core: PASSED **");
		else
			$display("** quaternion_to_euler_angles_core: FAILED **");
		$finish;
	end

	initial begin
		#2ms;
		$display("Timeout with %0d words outstanding", pending_count);
		$display("** quaternion_to_euler_angles_core: FAILED **");
		$finish;
	end
endmodule
